### rtl/core/b64d_pkg.sv
package b64d_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_PAD  = 3'd1,
      ST_BAD_LEN  = 3'd2,
      ST_BAD_CHAR = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_LEFTOVER = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       done_res;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   // URL-safe alphabet lookup
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
         s = '{hit: 1'b1, value: d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd26;
         s = '{hit: 1'b1, value: d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
         s = '{hit: 1'b1, value: d[5:0]};
      end else if (c == 8'h2D) begin
         s = '{hit: 1'b1, value: 6'd62};
      end else if (c == 8'h5F) begin
         s = '{hit: 1'b1, value: 6'd63};
      end
      return s;
   endfunction

endpackage

### rtl/core/b64d_if.sv
interface b64d_req_if;
   import b64d_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface b64d_rsp_if;
   import b64d_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/base64url_strict_decoder.sv
// An accepted req beat passes through the input register and then the result register to the rsp beat.
// Throughput: 1 beat per cycle while rsp is not stalled; the per-character state update is combinational.
// A stalled rsp holds the result register and then the input register.
// Reset: synchronous, active high; clears message state, valids; byte limit to all ones.
module base64url_strict_decoder #(
   parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   b64d_req_if.sink               req,
   b64d_rsp_if.source             rsp,
   input  logic                   csr_wen,
   input  logic [COUNT_WIDTH-1:0] csr_wdata
);
   import b64d_pkg::*;

   logic                   in_valid_ff;
   req_type                in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_item_ff;
   logic [COUNT_WIDTH-1:0] max_ff;
   logic                   advance;
   rsp_type                result;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);
   assign rsp.valid    = out_valid_ff;
   assign rsp.payload  = out_item_ff;

   b64d_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (in_item_ff),
      .byte_limit (max_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= '1;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_wen) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff <= req.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced beat did not reach result register");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.done_res |-> out_item_ff.status == ST_OK)
      else $error("status reported on a non-final beat");

   a_stall_no_advance: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

### rtl/core/b64d_core.sv
module b64d_core #(
   parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  b64d_pkg::req_type      item,
   input  logic [COUNT_WIDTH-1:0] byte_limit,
   output b64d_pkg::rsp_type      result
);
   import b64d_pkg::*;

   logic [11:0]          acc_ff, acc_in;
   logic [2:0]           pend_ff, pend_in;
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           pad_ff, pad_in;
   logic [COUNT_WIDTH:0] cnt_ff, cnt_in;
   status_type           err_ff, err_in;

   sextet_type  sx;
   logic        is_pad;
   logic [3:0]  bits;
   logic [11:0] shifted;
   logic [11:0] mask;
   logic [1:0]  eff;

   always_comb begin
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      phase_in = phase_ff + 2'd1;
      pad_in   = pad_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      result   = '0;
      result.status = ST_OK;
      sx       = sextet_of(item.char_code);
      is_pad   = item.char_code == PAD_CHAR;
      bits     = {1'b0, pend_ff} + 4'd6;
      shifted  = '0;
      mask     = '0;
      eff      = '0;

      if (is_pad) begin
         if (pad_ff != 2'd3) begin
            pad_in = pad_ff + 2'd1;
         end
      end else begin
         pad_in = '0;
         if (pad_ff != 2'd0 || !sx.hit) begin
            if (err_ff == ST_OK) begin
               err_in = ST_BAD_CHAR;
            end
         end else if (err_ff == ST_OK) begin
            acc_in = {acc_ff[5:0], sx.value};
            if (bits >= 4'd8) begin
               bits    = bits - 4'd8;
               shifted = acc_in >> bits;
               result.data_byte  = shifted[7:0];
               result.byte_valid = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_in > {1'b0, byte_limit}) begin
                  err_in = ST_OVERFLOW;
               end
            end
            pend_in = bits[2:0];
         end
      end

      if (item.last_char) begin
         result.done_res = 1'b1;
         eff  = phase_in - pad_in;
         mask = (12'd1 << pend_in) - 12'd1;
         if (pad_in == 2'd3) begin
            result.status = ST_BAD_PAD;
         end else if (eff == 2'd1) begin
            result.status = ST_BAD_LEN;
         end else if (pad_in != 2'd0 &&
                      (eff == 2'd0 || {1'b0, pad_in} != 3'd4 - {1'b0, eff})) begin
            result.status = ST_BAD_PAD;
         end else if (err_in != ST_OK) begin
            result.status = err_in;
         end else if ((acc_in & mask) != 12'd0) begin
            result.status = ST_LEFTOVER;
         end
         acc_in   = '0;
         pend_in  = '0;
         phase_in = '0;
         pad_in   = '0;
         cnt_in   = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pend_ff  <= '0;
         phase_ff <= '0;
         pad_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= ST_OK;
      end else if (advance) begin
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   a_no_byte_after_error: assert property (@(posedge clock) disable iff (reset)
      advance && err_ff != ST_OK |-> !result.byte_valid)
      else $error("byte emitted after latched error");

   a_pend_even: assert property (@(posedge clock) disable iff (reset)
      pend_ff[0] == 1'b0)
      else $error("pending bit count out of range");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      advance && item.last_char |=>
         pend_ff == 3'd0 && cnt_ff == '0 && err_ff == ST_OK && pad_ff == 2'd0)
      else $error("message state not cleared after last beat");

endmodule

### dv/base64url_strict_decoder_checker.sv
`timescale 1ns / 1ps

module base64url_strict_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if         req,
   b64d_rsp_if         rsp,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_cnt,
   output int          done_ok,
   output int          done_bad
);
   import b64d_pkg::*;

   logic [11:0]  acc;
   int unsigned  pend;
   logic [1:0]   phase;
   logic [1:0]   pads;
   int unsigned  n_emitted;
   status_type   err;
   int unsigned  byte_limit;
   rsp_type      expected_rsp[$];

   function automatic void clear_message();
      acc       = '0;
      pend      = 0;
      phase     = '0;
      pads      = '0;
      n_emitted = 0;
      err       = ST_OK;
   endfunction

   function automatic rsp_type decode_step(logic [7:0] c, logic last);
      rsp_type     r;
      logic [5:0]  v;
      logic        hit;
      logic        after_pad;
      logic [1:0]  eff;
      int unsigned bits;
      r          = '0;
      r.done_res = last;
      r.status   = ST_OK;
      phase      = phase + 2'd1;
      if (c == PAD_CHAR) begin
         if (pads != 2'd3) pads = pads + 2'd1;
      end else begin
         after_pad = (pads != 2'd0);
         pads      = 2'd0;
         hit       = 1'b1;
         v         = '0;
         if (c >= "A" && c <= "Z") v = 6'(c - "A");
         else if (c >= "a" && c <= "z") v = 6'(c - "a" + 8'd26);
         else if (c >= "0" && c <= "9") v = 6'(c - "0" + 8'd52);
         else if (c == "-") v = 6'd62;
         else if (c == "_") v = 6'd63;
         else hit = 1'b0;
         if (after_pad || !hit) begin
            if (err == ST_OK) err = ST_BAD_CHAR;
         end else if (err == ST_OK) begin
            bits = pend + 6;
            acc  = {acc[5:0], v};
            if (bits >= 8) begin
               bits         = bits - 8;
               r.data_byte  = 8'(acc >> bits);
               r.byte_valid = 1'b1;
               n_emitted++;
               if (n_emitted > byte_limit) err = ST_OVERFLOW;
            end
            pend = bits;
         end
      end
      if (last) begin
         eff = phase - pads;
         if (pads == 2'd3) r.status = ST_BAD_PAD;
         else if (eff == 2'd1) r.status = ST_BAD_LEN;
         else if (pads != 2'd0 && (eff == 2'd0 || int'(pads) != 4 - int'(eff)))
            r.status = ST_BAD_PAD;
         else if (err != ST_OK) r.status = err;
         else if (pend != 0 && (acc & ((12'd1 << pend) - 12'd1)) != 12'd0)
            r.status = ST_LEFTOVER;
         clear_message();
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         clear_message();
         byte_limit = 32'hFFFF;
         expected_rsp.delete();
         fail_count = 0;
         done_ok    = 0;
         done_bad   = 0;
      end else begin
         if (csr_wen) byte_limit = 32'(csr_wdata);
         if (req.valid && req.ready)
            expected_rsp.insert(expected_rsp.size(),
                                decode_step(req.payload.char_code,
                                            req.payload.last_char));
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("chk: rsp beat with nothing pending: byte %02h v %0b d %0b st %0d",
                           got.data_byte, got.byte_valid, got.done_res, got.status);
            end else begin
               want = expected_rsp.pop_front();
               if (want.done_res) begin
                  if (want.status == ST_OK) done_ok++;
                  else done_bad++;
               end
               if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
                   got.done_res !== want.done_res || got.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"chk: mismatch: exp byte %02h v %0b d %0b st %0d, ",
                               "got byte %02h v %0b d %0b st %0d"},
                              want.data_byte, want.byte_valid, want.done_res, want.status,
                              got.data_byte, got.byte_valid, got.done_res, got.status);
               end
            end
         end
      end
      pending_cnt = expected_rsp.size();
   end

endmodule

### dv/base64url_strict_decoder_test.sv
`timescale 1ns / 1ps

module base64url_strict_decoder_test;
   import b64d_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_CHARS = 96;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen;
   logic [15:0] csr_wdata;

   int fail_count;
   int pending_cnt;
   int done_ok;
   int done_bad;
   int cycle_cnt = 0;
   int n_chars   = 0;
   int n_msgs    = 0;
   int n_writes  = 0;
   int send_idle = 0;
   int stall_pct = 0;
   int hold_left;
   logic hold_req = 1'b0;
   logic hold_done;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   b64d_req_if req_bus ();
   b64d_rsp_if rsp_bus ();

   base64url_strict_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   base64url_strict_decoder_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending_cnt (pending_cnt),
      .done_ok     (done_ok),
      .done_bad    (done_bad)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_cnt);
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_char(logic [7:0] c, logic last);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= '{char_code: c, last_char: last};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n_chars++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
      n_msgs++;
   endtask

   task automatic write_byte_limit(int unsigned value);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_cnt != 0);
      repeat (3) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
      n_writes++;
   endtask

   // mostly valid encodings of random bytes; the rest broken in various ways
   task automatic send_random_message();
      logic [7:0]  data[$];
      logic [7:0]  text[$];
      logic [23:0] grp;
      int nbytes;
      int n;
      int data_len;
      nbytes = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < nbytes + 2; i++) data.insert(data.size(), 8'($urandom));
      n = 3;
      for (int i = 0; i < nbytes; i += 3) begin
         n   = (nbytes - i > 3) ? 3 : nbytes - i;
         grp = {data[i], data[i+1], data[i+2]};
         text.insert(text.size(), alphabet[grp[23:18]]);
         text.insert(text.size(), alphabet[grp[17:12]]);
         if (n > 1) text.insert(text.size(), alphabet[grp[11:6]]);
         if (n > 2) text.insert(text.size(), alphabet[grp[5:0]]);
      end
      data_len = text.size();
      if (n < 3 && $urandom_range(1) == 1) repeat (3 - n) text.insert(text.size(), PAD_CHAR);
      if ($urandom_range(99) >= 65) begin
         case ($urandom_range(6))
            0: text[$urandom_range(text.size() - 1)] = 8'($urandom);
            1: text.pop_back();
            2: repeat ($urandom_range(1, 3)) text.insert(text.size(), PAD_CHAR);
            3: text.insert($urandom_range(text.size() - 1), PAD_CHAR);
            4: text[data_len - 1] = alphabet[$urandom_range(63)];
            5: begin
               text.delete();
               repeat ($urandom_range(1, 4)) text.insert(text.size(), PAD_CHAR);
            end
            default: begin
               text.delete();
               repeat ($urandom_range(1, 8)) text.insert(text.size(), 8'($urandom));
            end
         endcase
      end
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
      n_msgs++;
   endtask

   initial begin
      int unsigned limits[8];
      int idle_mode[4];
      int stall_mode[4];
      int target;
      limits     = '{0, 1, 32'hFFFF, 3, $urandom_range(4, 20), 2, $urandom_range(65535),
                     32'hFFFF};
      idle_mode  = '{0, 49, 0, 6};
      stall_mode = '{0, 0, 49, 6};
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_wen         = 1'b0;
      csr_wdata       = 16'hFFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("TWFu");
      send_text("TQ==");
      send_text("TR");
      send_text("A");
      send_text("=");
      send_text("AA===");
      send_text("QQ=Q");
      send_text("-_");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      n_msgs++;

      for (int p = 0; p < 8; p++) begin
         write_byte_limit(limits[p]);
         send_idle = idle_mode[p % 4];
         stall_pct = stall_mode[p % 4];
         target    = n_chars + PHASE_CHARS;
         while (n_chars < target) begin
            // sender keeps offering while the result side is held off
            if (p == 4 && n_chars > target - 80) hold_req = 1'b1;
            send_random_message();
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_cnt != 0);
      repeat (8) @(posedge clock);
      $display("tb: %0d characters in %0d messages, %0d byte limit settings (0 to 65535)",
               n_chars, n_msgs, n_writes);
      $display("tb: %0d messages ended ok, %0d with an error status; one long result stall",
               done_ok, done_bad);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_if.sv
rtl/core/b64d_core.sv
rtl/core/base64url_strict_decoder.sv
dv/base64url_strict_decoder_checker.sv
dv/base64url_strict_decoder_test.sv
